FILE: design/led_chase_blink_sequencer_unit_assert.svh
// Assertion macros used by the checker of the LED effect sequencer.
`ifndef LED_CHASE_BLINK_SEQUENCER_UNIT_ASSERT_SVH
`define LED_CHASE_BLINK_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCBS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcbs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcbs assertion failed");

`endif

FILE: design/lcbs_pkg.sv
// Types and constants of the LED chase and blink sequencer.
package lcbs_pkg;

  localparam int REQ_W     = 3;
  localparam int COLOR_W   = 8;
  localparam int RGB_W     = 24;
  localparam int IDX_W     = 3;
  localparam int TICK_W    = 16;
  localparam int TRAIL_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [TICK_W-1:0]  TICKS_RESET = 16'd10;
  localparam logic [TRAIL_W-1:0] TRAIL_RESET = 3'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_EQUAL     = 3'd1,
    REQ_RUN       = 3'd2,
    REQ_BLINK     = 3'd3,
    REQ_RUN_BLINK = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLINK_ON  = 3'd0,
    CFG_BLINK_OFF = 3'd1,
    CFG_RUN_STEP  = 3'd2,
    CFG_TRAIL     = 3'd3,
    CFG_BLINK_RGB = 3'd4,
    CFG_RUN_RGB   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_EQUAL = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_CHASE = 2'd3
  } mode_e;

  typedef enum logic {
    BURST_ALL  = 1'b0,
    BURST_PAIR = 1'b1
  } burst_e;

endpackage

FILE: design/lcbs_req_if.sv
// Request channel interface: ticks and mode commands.
interface lcbs_req_if;
  logic                            valid;
  logic                            ready;
  logic [lcbs_pkg::REQ_W-1:0]      req_type;
  logic [lcbs_pkg::COLOR_W-1:0]    red_in;
  logic [lcbs_pkg::COLOR_W-1:0]    green_in;
  logic [lcbs_pkg::COLOR_W-1:0]    blue_in;

  modport source(output valid, output req_type, output red_in, output green_in,
                 output blue_in, input ready);
  modport sink(input valid, input req_type, input red_in, input green_in,
               input blue_in, output ready);
endinterface

FILE: design/lcbs_res_if.sv
// Result channel interface: one LED color write per item.
interface lcbs_res_if;
  logic                            valid;
  logic                            ready;
  logic [lcbs_pkg::IDX_W-1:0]      led_index;
  logic [lcbs_pkg::COLOR_W-1:0]    red_out;
  logic [lcbs_pkg::COLOR_W-1:0]    green_out;
  logic [lcbs_pkg::COLOR_W-1:0]    blue_out;
  logic                            drive_enabled;
  logic                            last;

  modport source(output valid, output led_index, output red_out, output green_out,
                 output blue_out, output drive_enabled, output last, input ready);
  modport sink(input valid, input led_index, input red_out, input green_out,
               input blue_out, input drive_enabled, input last, output ready);
endinterface

FILE: design/led_chase_blink_sequencer_unit.sv
// Top level of the LED chase and blink sequencer.
// An accepted item is held in an input register and then evaluated, where it updates
// the effect state and may load a write burst into the burst register; each color
// write passes from the burst register to the output register. Items that cause no
// write pass at one per cycle while no burst is in progress. The write emitter issues
// one write per cycle while the output register can take it: NUM_LEDS writes for a full
// update (set equal, blink on or off) and two for a running or chase step, and the next
// item is evaluated in the cycle the last write of the burst is emitted. A stalled result
// channel holds the output register and the burst, and with them the input side.
module led_chase_blink_sequencer_unit #(
  parameter int NUM_LEDS   = 5,
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lcbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcbs_pkg::RGB_W-1:0]      cfg_data_i,
  lcbs_req_if.sink                        req_i,
  lcbs_res_if.source                      res_o
);

  localparam int CW = (TIMER_BITS > lcbs_pkg::TICK_W) ? TIMER_BITS : lcbs_pkg::TICK_W;
  localparam logic [CW-1:0] TMAX_C = CW'({TIMER_BITS{1'b1}});
  localparam logic [lcbs_pkg::IDX_W-1:0] LAST_LED = lcbs_pkg::IDX_W'(NUM_LEDS - 1);
  localparam logic [lcbs_pkg::IDX_W:0] N_W = (lcbs_pkg::IDX_W + 1)'(NUM_LEDS);

  // Configuration registers.
  logic [lcbs_pkg::TICK_W-1:0]  on_ticks_q, off_ticks_q, step_ticks_q;
  logic [lcbs_pkg::TRAIL_W-1:0] trail_q;
  logic [lcbs_pkg::RGB_W-1:0]   blink_rgb_q, run_rgb_q;

  // Effect state.
  lcbs_pkg::mode_e              mode_q, mode_d;
  logic [lcbs_pkg::IDX_W-1:0]   lit_q, lit_d;
  logic                         on_q, on_d;
  logic [TIMER_BITS-1:0]        rt_q, rt_d, bt_q, bt_d;
  logic                         en_q, en_d;

  // Input register.
  logic                         iv_q;
  logic [lcbs_pkg::REQ_W-1:0]   ireq_q;
  logic [lcbs_pkg::RGB_W-1:0]   icol_q;

  // Burst register.
  logic                         bv_q;
  lcbs_pkg::burst_e             bkind_q, bkind_d;
  logic [lcbs_pkg::IDX_W-1:0]   bk_q;
  logic [lcbs_pkg::IDX_W-1:0]   bled_a_q, bled_b_q, bled_a_d, bled_b_d;
  logic [lcbs_pkg::RGB_W-1:0]   bcol_a_q, bcol_b_q, bcol_a_d, bcol_b_d;
  logic                         ben_q;
  logic                         go_d;

  // Output register.
  logic                         ov_q;
  logic [lcbs_pkg::IDX_W-1:0]   oled_q;
  logic [lcbs_pkg::RGB_W-1:0]   ocol_q;
  logic                         oen_q, olast_q;

  logic                         emit, emit_last, proc;
  logic [lcbs_pkg::IDX_W-1:0]   e_led;
  logic [lcbs_pkg::RGB_W-1:0]   e_col;

  logic [TIMER_BITS-1:0]        rt_inc, bt_inc, sat_step, sat_off;
  logic                         rt_ge_step, rt_ge_on, rt_ge_off, bt_ge_on, bt_ge_off;
  logic [lcbs_pkg::IDX_W-1:0]   next_pos, fade_pos;
  logic [lcbs_pkg::IDX_W:0]     trail_mod, fade_sum;

  assign emit_last = (bkind_q == lcbs_pkg::BURST_ALL) ? (bk_q == LAST_LED)
                                                      : (bk_q == lcbs_pkg::IDX_W'(1));
  assign emit      = bv_q && (!ov_q || res_o.ready);
  assign proc      = iv_q && (!bv_q || (emit && emit_last));
  assign req_i.ready = !iv_q || proc;

  always_comb begin
    if (bkind_q == lcbs_pkg::BURST_ALL) begin
      e_led = bk_q;
      e_col = bcol_a_q;
    end else if (bk_q == '0) begin
      e_led = bled_a_q;
      e_col = bcol_a_q;
    end else begin
      e_led = bled_b_q;
      e_col = bcol_b_q;
    end
  end

  // Timers count up and saturate; limits compare at the wider of the two widths.
  assign rt_inc = (rt_q == {TIMER_BITS{1'b1}}) ? rt_q : rt_q + 1'b1;
  assign bt_inc = (bt_q == {TIMER_BITS{1'b1}}) ? bt_q : bt_q + 1'b1;
  assign rt_ge_step = CW'(rt_inc) >= CW'(step_ticks_q);
  assign rt_ge_on   = CW'(rt_inc) >= CW'(on_ticks_q);
  assign rt_ge_off  = CW'(rt_inc) >= CW'(off_ticks_q);
  assign bt_ge_on   = CW'(bt_inc) >= CW'(on_ticks_q);
  assign bt_ge_off  = CW'(bt_inc) >= CW'(off_ticks_q);
  assign sat_step = (CW'(step_ticks_q) > TMAX_C) ? {TIMER_BITS{1'b1}}
                                                 : TIMER_BITS'(CW'(step_ticks_q));
  assign sat_off  = (CW'(off_ticks_q) > TMAX_C) ? {TIMER_BITS{1'b1}}
                                                : TIMER_BITS'(CW'(off_ticks_q));

  assign next_pos = (lit_q == LAST_LED) ? '0 : lit_q + 1'b1;

  always_comb begin
    trail_mod = {1'b0, trail_q};
    for (int i = 0; i < 4; i++) begin
      if (trail_mod >= N_W) begin
        trail_mod = trail_mod - N_W;
      end
    end
  end

  always_comb begin
    fade_sum = {1'b0, next_pos} + N_W - trail_mod;
    if (fade_sum >= N_W) begin
      fade_sum = fade_sum - N_W;
    end
  end
  assign fade_pos = fade_sum[lcbs_pkg::IDX_W-1:0];

  always_comb begin
    mode_d   = mode_q;
    lit_d    = lit_q;
    on_d     = on_q;
    rt_d     = rt_q;
    bt_d     = bt_q;
    en_d     = en_q;
    go_d     = 1'b0;
    bkind_d  = lcbs_pkg::BURST_ALL;
    bled_a_d = lit_q;
    bled_b_d = next_pos;
    bcol_a_d = '0;
    bcol_b_d = '0;
    case (lcbs_pkg::req_e'(ireq_q))
      lcbs_pkg::REQ_TICK: begin
        rt_d = rt_inc;
        bt_d = bt_inc;
        case (mode_q)
          lcbs_pkg::MODE_RUN: begin
            if (rt_ge_step) begin
              rt_d     = '0;
              go_d     = 1'b1;
              bkind_d  = lcbs_pkg::BURST_PAIR;
              bled_a_d = lit_q;
              bled_b_d = next_pos;
              bcol_b_d = run_rgb_q;
              lit_d    = next_pos;
            end
          end
          lcbs_pkg::MODE_BLINK: begin
            if (on_q) begin
              if (rt_ge_on) begin
                rt_d = '0;
                go_d = 1'b1;
                on_d = 1'b0;
              end
            end else if (rt_ge_off) begin
              rt_d     = '0;
              go_d     = 1'b1;
              bcol_a_d = blink_rgb_q;
              on_d     = 1'b1;
            end
          end
          lcbs_pkg::MODE_CHASE: begin
            if (on_q) begin
              if (bt_ge_on) begin
                bt_d = '0;
                go_d = 1'b1;
                on_d = 1'b0;
              end
            end else begin
              if (bt_ge_off) begin
                bt_d = '0;
              end
              if (bt_ge_off && (blink_rgb_q != '0)) begin
                go_d     = 1'b1;
                bcol_a_d = blink_rgb_q;
                on_d     = 1'b1;
              end else begin
                if (rt_ge_step) begin
                  rt_d = '0;
                end
                if (rt_ge_step && (run_rgb_q != '0)) begin
                  go_d     = 1'b1;
                  bkind_d  = lcbs_pkg::BURST_PAIR;
                  bled_a_d = next_pos;
                  bcol_a_d = run_rgb_q;
                  bled_b_d = fade_pos;
                  lit_d    = next_pos;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      lcbs_pkg::REQ_EQUAL: begin
        en_d     = 1'b1;
        mode_d   = lcbs_pkg::MODE_EQUAL;
        go_d     = 1'b1;
        bcol_a_d = icol_q;
      end
      lcbs_pkg::REQ_RUN: begin
        mode_d = lcbs_pkg::MODE_RUN;
        lit_d  = '0;
        rt_d   = sat_step;
      end
      lcbs_pkg::REQ_BLINK: begin
        mode_d = lcbs_pkg::MODE_BLINK;
        on_d   = 1'b0;
        rt_d   = sat_off;
      end
      lcbs_pkg::REQ_RUN_BLINK: begin
        en_d   = 1'b1;
        mode_d = lcbs_pkg::MODE_CHASE;
        lit_d  = '0;
        on_d   = 1'b0;
        bt_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_ticks_q   <= lcbs_pkg::TICKS_RESET;
      off_ticks_q  <= lcbs_pkg::TICKS_RESET;
      step_ticks_q <= lcbs_pkg::TICKS_RESET;
      trail_q      <= lcbs_pkg::TRAIL_RESET;
      blink_rgb_q  <= '0;
      run_rgb_q    <= '0;
    end else if (cfg_we_i) begin
      case (lcbs_pkg::cfg_reg_e'(cfg_idx_i))
        lcbs_pkg::CFG_BLINK_ON:  on_ticks_q   <= cfg_data_i[lcbs_pkg::TICK_W-1:0];
        lcbs_pkg::CFG_BLINK_OFF: off_ticks_q  <= cfg_data_i[lcbs_pkg::TICK_W-1:0];
        lcbs_pkg::CFG_RUN_STEP:  step_ticks_q <= cfg_data_i[lcbs_pkg::TICK_W-1:0];
        lcbs_pkg::CFG_TRAIL:     trail_q      <= cfg_data_i[lcbs_pkg::TRAIL_W-1:0];
        lcbs_pkg::CFG_BLINK_RGB: blink_rgb_q  <= cfg_data_i;
        lcbs_pkg::CFG_RUN_RGB:   run_rgb_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lcbs_pkg::MODE_EQUAL;
      lit_q  <= '0;
      on_q   <= 1'b0;
      rt_q   <= '0;
      bt_q   <= '0;
      en_q   <= 1'b0;
    end else if (proc) begin
      mode_q <= mode_d;
      lit_q  <= lit_d;
      on_q   <= on_d;
      rt_q   <= rt_d;
      bt_q   <= bt_d;
      en_q   <= en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      iv_q <= 1'b1;
    end else if (proc) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      ireq_q <= req_i.req_type;
      icol_q <= {req_i.red_in, req_i.green_in, req_i.blue_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= 1'b0;
      bk_q    <= '0;
      bkind_q <= lcbs_pkg::BURST_ALL;
    end else if (proc && go_d) begin
      bv_q    <= 1'b1;
      bk_q    <= '0;
      bkind_q <= bkind_d;
    end else if (emit && emit_last) begin
      bv_q <= 1'b0;
    end else if (emit) begin
      bk_q <= bk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && go_d) begin
      bled_a_q <= bled_a_d;
      bled_b_q <= bled_b_d;
      bcol_a_q <= bcol_a_d;
      bcol_b_q <= bcol_b_d;
      ben_q    <= en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      oled_q  <= e_led;
      ocol_q  <= e_col;
      oen_q   <= ben_q;
      olast_q <= emit_last;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.led_index     = oled_q;
  assign res_o.red_out       = ocol_q[23:16];
  assign res_o.green_out     = ocol_q[15:8];
  assign res_o.blue_out      = ocol_q[7:0];
  assign res_o.drive_enabled = oen_q;
  assign res_o.last          = olast_q;

endmodule

FILE: design/lcbs_checker.sv
// Port-level checker for the LED effect sequencer and its bind statement.
`include "led_chase_blink_sequencer_unit_assert.svh"

module lcbs_checker #(
  parameter int NUM_LEDS = 5
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [lcbs_pkg::IDX_W-1:0]     res_led_index_i,
  input logic [lcbs_pkg::COLOR_W-1:0]   res_red_i,
  input logic [lcbs_pkg::COLOR_W-1:0]   res_green_i,
  input logic [lcbs_pkg::COLOR_W-1:0]   res_blue_i,
  input logic                           res_drive_enabled_i,
  input logic                           res_last_i
);

  logic any_in_q;
  logic seen_en_q;
  logic led_ok;
  logic res_stall;
  logic res_take;
  logic [lcbs_pkg::IDX_W+3*lcbs_pkg::COLOR_W+1:0] res_word;

  assign led_ok    = {1'b0, res_led_index_i} < (lcbs_pkg::IDX_W + 1)'(NUM_LEDS);
  assign res_stall = res_valid_i && !res_ready_i;
  assign res_take  = res_valid_i && res_ready_i;
  assign res_word  = {res_led_index_i, res_red_i, res_green_i, res_blue_i,
                      res_drive_enabled_i, res_last_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_in_q  <= 1'b0;
      seen_en_q <= 1'b0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        any_in_q <= 1'b1;
      end
      if (res_take && res_drive_enabled_i) begin
        seen_en_q <= 1'b1;
      end
    end
  end

  `LCBS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_stall, res_valid_i && $stable(res_word))
  `LCBS_ASSERT_NOW(a_led_range, clk_i, rst_ni, res_valid_i, led_ok)
  `LCBS_ASSERT_NOW(a_enable_sticks, clk_i, rst_ni, res_valid_i && seen_en_q, res_drive_enabled_i)
  `LCBS_ASSERT_NOW(a_no_result_first, clk_i, rst_ni, res_valid_i, any_in_q)

endmodule

bind led_chase_blink_sequencer_unit lcbs_checker #(.NUM_LEDS(NUM_LEDS)) u_lcbs_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .res_led_index_i     (res_o.led_index),
  .res_red_i           (res_o.red_out),
  .res_green_i         (res_o.green_out),
  .res_blue_i          (res_o.blue_out),
  .res_drive_enabled_i (res_o.drive_enabled),
  .res_last_i          (res_o.last)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the LED chase and blink sequencer with a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import lcbs_pkg::*;

  localparam int NUM_LEDS     = 5;
  localparam int REQ_CODE_MAX = (1 << REQ_W) - 1;
  localparam int TRAIL_MAX    = (1 << TRAIL_W) - 1;
  localparam int GAP_MAX      = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_CAP   = 40;
  localparam logic [TICK_W-1:0] TIMER_MAX = '1;

  typedef struct packed {
    logic [IDX_W-1:0]   led;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               drive;
    logic               last;
  } led_write_t;

  typedef enum int {
    PACE_BURST,
    PACE_SLOW,
    PACE_MIXED
  } pace_e;

  class led_write_board;
    led_write_t due_writes[$];
    int fails;

    logic [TICK_W-1:0]  on_ticks, off_ticks, step_ticks;
    logic [TRAIL_W-1:0] trail;
    logic [RGB_W-1:0]   blink_color, run_color;

    mode_e              mode;
    logic [IDX_W-1:0]   lit_pos;
    logic               blink_on;
    logic [TICK_W-1:0]  run_tmr, blink_tmr;
    logic               drive_en;

    function new();
      fails       = 0;
      on_ticks    = TICKS_RESET;
      off_ticks   = TICKS_RESET;
      step_ticks  = TICKS_RESET;
      trail       = TRAIL_RESET;
      blink_color = '0;
      run_color   = '0;
      mode        = MODE_EQUAL;
      lit_pos     = '0;
      blink_on    = 1'b0;
      run_tmr     = '0;
      blink_tmr   = '0;
      drive_en    = 1'b0;
    endfunction

    function int pending();
      return due_writes.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [RGB_W-1:0] data);
      case (idx)
        CFG_BLINK_ON:  on_ticks = data[TICK_W-1:0];
        CFG_BLINK_OFF: off_ticks = data[TICK_W-1:0];
        CFG_RUN_STEP:  step_ticks = data[TICK_W-1:0];
        CFG_TRAIL:     trail = data[TRAIL_W-1:0];
        CFG_BLINK_RGB: blink_color = data;
        CFG_RUN_RGB:   run_color = data;
        default: ;
      endcase
    endfunction

    function void add_write(int led, logic [RGB_W-1:0] rgb, logic last);
      led_write_t w;
      w.led   = IDX_W'(led);
      w.red   = rgb[23:16];
      w.green = rgb[15:8];
      w.blue  = rgb[7:0];
      w.drive = drive_en;
      w.last  = last;
      due_writes.push_back(w);
    endfunction

    function void fill_all(logic [RGB_W-1:0] rgb);
      for (int i = 0; i < NUM_LEDS; i++) begin
        add_write(i, rgb, i == NUM_LEDS - 1);
      end
    endfunction

    function void step_tick();
      int pos;
      logic [TICK_W-1:0] lim;
      logic off_done, step_done;
      pos = lit_pos % NUM_LEDS;
      if (run_tmr != TIMER_MAX) run_tmr++;
      if (blink_tmr != TIMER_MAX) blink_tmr++;
      case (mode)
        MODE_RUN: begin
          if (run_tmr >= step_ticks) begin
            run_tmr = '0;
            add_write(pos, '0, 1'b0);
            pos = (pos + 1) % NUM_LEDS;
            lit_pos = IDX_W'(pos);
            add_write(pos, run_color, 1'b1);
          end
        end
        MODE_BLINK: begin
          lim = blink_on ? on_ticks : off_ticks;
          if (run_tmr >= lim) begin
            run_tmr = '0;
            fill_all(blink_on ? '0 : blink_color);
            blink_on = !blink_on;
          end
        end
        MODE_CHASE: begin
          if (blink_on) begin
            if (blink_tmr >= on_ticks) begin
              blink_tmr = '0;
              fill_all('0);
              blink_on = 1'b0;
            end
          end else begin
            // The off timer restarts even when a black blink color suppresses the flash.
            off_done = blink_tmr >= off_ticks;
            if (off_done) blink_tmr = '0;
            if (off_done && blink_color != '0) begin
              fill_all(blink_color);
              blink_on = 1'b1;
            end else begin
              step_done = run_tmr >= step_ticks;
              if (step_done) run_tmr = '0;
              if (step_done && run_color != '0) begin
                pos = (pos + 1) % NUM_LEDS;
                lit_pos = IDX_W'(pos);
                add_write(pos, run_color, 1'b0);
                add_write((pos + NUM_LEDS - (int'(trail) % NUM_LEDS)) % NUM_LEDS, '0, 1'b1);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [COLOR_W-1:0] r,
                               logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
      case (kind)
        REQ_TICK: step_tick();
        REQ_EQUAL: begin
          drive_en = 1'b1;
          mode = MODE_EQUAL;
          fill_all({r, g, b});
        end
        REQ_RUN: begin
          mode = MODE_RUN;
          lit_pos = '0;
          run_tmr = step_ticks;
        end
        REQ_BLINK: begin
          mode = MODE_BLINK;
          blink_on = 1'b0;
          run_tmr = off_ticks;
        end
        REQ_RUN_BLINK: begin
          drive_en = 1'b1;
          mode = MODE_CHASE;
          lit_pos = '0;
          blink_on = 1'b0;
          blink_tmr = '0;
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      if (fails < REPORT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      fails++;
    endtask

    task check_write(led_write_t got);
      led_write_t want;
      if (due_writes.size() == 0) begin
        report($sformatf("unexpected write to LED %0d", got.led));
        return;
      end
      want = due_writes.pop_front();
      if (got.led !== want.led)
        report($sformatf("led_index %0d, want %0d", got.led, want.led));
      if (got.red !== want.red)
        report($sformatf("red_out %h, want %h (LED %0d)", got.red, want.red, want.led));
      if (got.green !== want.green)
        report($sformatf("green_out %h, want %h (LED %0d)", got.green, want.green, want.led));
      if (got.blue !== want.blue)
        report($sformatf("blue_out %h, want %h (LED %0d)", got.blue, want.blue, want.led));
      if (got.drive !== want.drive)
        report($sformatf("drive_enabled %b, want %b (LED %0d)", got.drive, want.drive,
                         want.led));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b (LED %0d)", got.last, want.last, want.led));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [RGB_W-1:0]     cfg_data;

  lcbs_req_if req_if();
  lcbs_res_if res_if();

  led_write_board board = new();
  pace_e req_pace = PACE_MIXED;
  pace_e res_pace = PACE_MIXED;

  led_chase_blink_sequencer_unit #(
    .NUM_LEDS(NUM_LEDS),
    .TIMER_BITS(TICK_W)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i(req_if),
    .res_o(res_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_gap(pace_e pace);
    case (pace)
      PACE_BURST: return 0;
      PACE_SLOW:  return $urandom_range(GAP_MAX, 0);
      default:    return ($urandom_range(3, 0) == 0) ? $urandom_range(GAP_MAX, 0) : 0;
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_level();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return COLOR_W'($urandom());
  endfunction

  function automatic logic [TICK_W-1:0] rand_ticks();
    int pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return TIMER_MAX;
    if (pick == 1) return TICK_W'($urandom_range(20, 7));
    return TICK_W'($urandom_range(6, 0));
  endfunction

  function automatic logic [RGB_W-1:0] rand_color();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 2) return '0;
    if (pick == 2) return '1;
    return RGB_W'($urandom());
  endfunction

  task automatic send_cmd(logic [REQ_W-1:0] kind, logic [COLOR_W-1:0] r,
                          logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
    int gap;
    if ($urandom_range(15, 0) == 0) req_pace = pace_e'($urandom_range(PACE_MIXED, PACE_BURST));
    gap = draw_gap(req_pace);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.red_in   <= r;
    req_if.green_in <= g;
    req_if.blue_in  <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    board.note_request(kind, r, g, b);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_e idx, logic [RGB_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic load_settings(logic [TICK_W-1:0] on_t, logic [TICK_W-1:0] off_t,
                               logic [TICK_W-1:0] step_t, logic [TRAIL_W-1:0] trail,
                               logic [RGB_W-1:0] blink_c, logic [RGB_W-1:0] run_c);
    settle();
    put_reg(CFG_BLINK_ON, RGB_W'(on_t));
    put_reg(CFG_BLINK_OFF, RGB_W'(off_t));
    put_reg(CFG_RUN_STEP, RGB_W'(step_t));
    put_reg(CFG_TRAIL, RGB_W'(trail));
    put_reg(CFG_BLINK_RGB, blink_c);
    put_reg(CFG_RUN_RGB, run_c);
    cfg_we <= 1'b0;
  endtask

  // Mostly a mode command followed by a run of ticks, with some stray requests mixed in.
  task automatic random_items(int count);
    int done, pick, n;
    logic [REQ_W-1:0] kind;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        kind = REQ_W'($urandom_range(REQ_CODE_MAX, 0));
        send_cmd(kind, rand_level(), rand_level(), rand_level());
        if (kind <= REQ_RUN_BLINK) done++;
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 20) kind = REQ_EQUAL;
        else if (pick < 40) kind = REQ_RUN;
        else if (pick < 60) kind = REQ_BLINK;
        else kind = REQ_RUN_BLINK;
        send_cmd(kind, rand_level(), rand_level(), rand_level());
        done++;
        n = $urandom_range(12, 1);
        repeat (n) begin
          send_cmd(REQ_TICK, rand_level(), rand_level(), rand_level());
          done++;
        end
      end
    end
  endtask

  initial begin
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_BLINK_ON;
    cfg_data        <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_TICK;
    req_if.red_in   <= '0;
    req_if.green_in <= '0;
    req_if.blue_in  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(REQ_TICK, '0, '0, '0);
    for (int k = REQ_RUN_BLINK + 1; k <= REQ_CODE_MAX; k++) begin
      send_cmd(REQ_W'(k), '1, '1, '1);
    end
    send_cmd(REQ_EQUAL, '0, '0, '0);
    send_cmd(REQ_EQUAL, '1, '1, '1);
    send_cmd(REQ_EQUAL, 8'h5A, 8'hC3, 8'h81);
    send_cmd(REQ_RUN, '0, '0, '0);
    repeat (3) send_cmd(REQ_TICK, '0, '0, '0);
    send_cmd(REQ_BLINK, '0, '0, '0);
    repeat (2) send_cmd(REQ_TICK, '0, '0, '0);
    send_cmd(REQ_RUN_BLINK, '0, '0, '0);
    repeat (3) send_cmd(REQ_TICK, '0, '0, '0);

    // A zero trail turns the freshly lit LED straight back off.
    load_settings(16'd1, 16'd2, 16'd1, '0, '1, 24'h000001);
    send_cmd(REQ_RUN_BLINK, '0, '0, '0);
    repeat (8) send_cmd(REQ_TICK, '0, '0, '0);
    random_items(20);

    load_settings('0, '0, '0, TRAIL_W'(4), 24'h800000, '1);
    random_items(25);

    load_settings(TIMER_MAX, TIMER_MAX, TIMER_MAX, TRAIL_W'(TRAIL_MAX), '0, '0);
    random_items(15);

    for (int p = 0; p < 7; p++) begin
      load_settings(rand_ticks(), rand_ticks(), rand_ticks(),
                    TRAIL_W'($urandom_range(TRAIL_MAX, 0)), rand_color(), rand_color());
      random_items(22);
    end

    settle();
    if (board.fails == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    led_write_t got;
    int gap;
    res_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(15, 0) == 0) res_pace = pace_e'($urandom_range(PACE_MIXED, PACE_BURST));
      gap = draw_gap(res_pace);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got = '{led: res_if.led_index, red: res_if.red_out, green: res_if.green_out,
              blue: res_if.blue_out, drive: res_if.drive_enabled, last: res_if.last};
      board.check_write(got);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
